[design/digital_pad_serial_responder_assert.svh]
// Assertion macros used by the pad responder RTL.
`ifndef DIGITAL_PAD_SERIAL_RESPONDER_ASSERT_SVH
`define DIGITAL_PAD_SERIAL_RESPONDER_ASSERT_SVH

// Same-cycle implication, checked on clk, muted during reset.
`define DPSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, muted during reset.
`define DPSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dpsr_pkg.sv]
// Types and constants for the digital pad serial responder.
package dpsr_pkg;

  // Item kinds carried in the action field
  typedef enum logic [1:0] {
    ACT_LATCH    = 2'd0,
    ACT_SELECT   = 2'd1,
    ACT_EXCHANGE = 2'd2
  } action_t;

  // Exchange sequence position
  typedef enum logic [2:0] {
    PH_WAIT_START = 3'd0,
    PH_WAIT_READ  = 3'd1,
    PH_BTN_LO     = 3'd2,
    PH_BTN_HI     = 3'd3,
    PH_DONE       = 3'd4
  } phase_t;

  localparam logic [7:0]  CMD_START    = 8'h01;
  localparam logic [7:0]  CMD_READ     = 8'h42;
  localparam logic [7:0]  ANS_ID       = 8'h41;
  localparam logic [7:0]  ANS_READY    = 8'h5a;
  localparam logic [7:0]  TX_IDLE      = 8'hff;
  localparam logic [15:0] ALL_RELEASED = 16'hffff;
  // Bits 1 and 2 are never reported as pressed
  localparam logic [15:0] BTN_MASK     = 16'hfff9;
  localparam logic [2:0]  LAST_BIT     = 3'd7;

endpackage

[design/dpsr_if.sv]
// Valid/ready channel interfaces for the pad responder input and result beats.
interface dpsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] buttons_pressed;
  logic        select_level;
  logic        data_in;

  modport source (output valid, action, buttons_pressed, select_level, data_in,
                  input ready);
  modport sink   (input valid, action, buttons_pressed, select_level, data_in,
                  output ready);
endinterface

interface dpsr_out_if;
  logic valid;
  logic ready;
  logic tx_bit;
  logic ack_pulse;

  modport source (output valid, tx_bit, ack_pulse, input ready);
  modport sink   (input valid, tx_bit, ack_pulse, output ready);
endinterface

[design/digital_pad_serial_responder.sv]
// Digital pad serial responder: device side of the pad exchange protocol.
//
// One beat in, one beat out: an item accepted at a clock edge
// updates the protocol state and loads the result register at that same edge,
// so the block takes a new beat every cycle while the result register drains
// (in_ch.ready is low only while a result waits and out_ch.ready is low). A latch
// beat stores the button word active low with bits 1 and 2 forced released; a
// select beat sets the select line, a rising edge restarting the exchange; an
// exchange beat trades one bit, LSB first, and answers 0x01 with 0x41, then
// 0x42 with 0x5A, then sends the low and high button bytes, flagging
// ack_pulse on every answered byte. Idle or deselected, tx_bit reads 1.
module digital_pad_serial_responder (
  input  logic clk,
  input  logic rst_n,
  dpsr_in_if.sink    in_ch,
  dpsr_out_if.source out_ch
);
  import dpsr_pkg::*;

  `include "digital_pad_serial_responder_assert.svh"

  // Protocol state
  logic        selected_r,    selected_nxt;
  logic [2:0]  bit_index_r,   bit_index_nxt;
  phase_t      phase_r,       phase_nxt;
  logic [7:0]  rx_byte_r,     rx_byte_nxt;
  logic [7:0]  tx_byte_r,     tx_byte_nxt;
  logic [15:0] button_word_r, button_word_nxt;

  // Result register
  logic out_valid_r;
  logic tx_bit_r,  tx_bit_nxt;
  logic ack_r,     ack_nxt;

  logic       in_fire;
  logic       do_exchange;
  logic       byte_done;
  logic [7:0] bit_mask;
  logic [7:0] rx_full;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign do_exchange = (in_ch.action == ACT_EXCHANGE) && selected_r;
  assign bit_mask    = 8'b1 << bit_index_r;
  assign rx_full     = (rx_byte_r & ~bit_mask) | ({7'd0, in_ch.data_in} << bit_index_r);
  assign byte_done   = do_exchange && (bit_index_r == LAST_BIT);

  // Next phase: restart on a select rising edge, advance on an answered byte
  always_comb begin
    phase_nxt = phase_r;
    if (in_ch.action == ACT_SELECT && !selected_r && in_ch.select_level) begin
      phase_nxt = PH_WAIT_START;
    end else if (byte_done) begin
      case (phase_r)
        PH_WAIT_START: if (rx_full == CMD_START) phase_nxt = PH_WAIT_READ;
        PH_WAIT_READ:  if (rx_full == CMD_READ)  phase_nxt = PH_BTN_LO;
        PH_BTN_LO:     phase_nxt = PH_BTN_HI;
        PH_BTN_HI:     phase_nxt = PH_DONE;
        default:       phase_nxt = phase_r;
      endcase
    end
  end

  // Datapath and result for the beat on offer
  always_comb begin
    selected_nxt    = selected_r;
    bit_index_nxt   = bit_index_r;
    rx_byte_nxt     = rx_byte_r;
    tx_byte_nxt     = tx_byte_r;
    button_word_nxt = button_word_r;
    tx_bit_nxt      = 1'b1;
    ack_nxt         = 1'b0;
    case (in_ch.action)
      ACT_LATCH: begin
        button_word_nxt = (in_ch.buttons_pressed & BTN_MASK) ^ ALL_RELEASED;
      end
      ACT_SELECT: begin
        if (!selected_r && in_ch.select_level) begin
          bit_index_nxt = '0;
          rx_byte_nxt   = '0;
          tx_byte_nxt   = TX_IDLE;
        end
        selected_nxt = in_ch.select_level;
      end
      ACT_EXCHANGE: begin
        if (selected_r) begin
          tx_bit_nxt    = tx_byte_r[bit_index_r];
          tx_byte_nxt   = tx_byte_r | bit_mask;
          rx_byte_nxt   = rx_full;
          bit_index_nxt = bit_index_r + 3'd1;
          if (bit_index_r == LAST_BIT) begin
            case (phase_r)
              PH_WAIT_START: begin
                if (rx_full == CMD_START) begin
                  ack_nxt     = 1'b1;
                  tx_byte_nxt = ANS_ID;
                end
              end
              PH_WAIT_READ: begin
                if (rx_full == CMD_READ) begin
                  ack_nxt     = 1'b1;
                  tx_byte_nxt = ANS_READY;
                end
              end
              PH_BTN_LO: begin
                ack_nxt     = 1'b1;
                tx_byte_nxt = button_word_r[7:0];
              end
              PH_BTN_HI: begin
                ack_nxt     = 1'b1;
                tx_byte_nxt = button_word_r[15:8];
              end
              default: ack_nxt = 1'b0;
            endcase
          end
        end
      end
      default: tx_bit_nxt = 1'b1;
    endcase
  end

  // State update on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      selected_r    <= 1'b0;
      bit_index_r   <= '0;
      phase_r       <= PH_WAIT_START;
      rx_byte_r     <= '0;
      tx_byte_r     <= TX_IDLE;
      button_word_r <= ALL_RELEASED;
    end else if (in_fire) begin
      selected_r    <= selected_nxt;
      bit_index_r   <= bit_index_nxt;
      phase_r       <= phase_nxt;
      rx_byte_r     <= rx_byte_nxt;
      tx_byte_r     <= tx_byte_nxt;
      button_word_r <= button_word_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tx_bit_r <= tx_bit_nxt;
      ack_r    <= ack_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tx_bit    = tx_bit_r;
  assign out_ch.ack_pulse = ack_r;

  // Checks
  `DPSR_ASSERT_NEXT(a_fire_loads_result, in_fire, out_valid_r,
    "accepted beat did not load a result")
  `DPSR_ASSERT_NEXT(a_deselected_idle,
    in_fire && !selected_r && (in_ch.action == ACT_EXCHANGE),
    tx_bit_r && !ack_r, "deselected exchange drove the line")
  `DPSR_ASSERT_SAME(a_ack_on_byte_edge, out_valid_r && ack_r, bit_index_r == 3'd0,
    "acknowledge not on a byte boundary")
  `DPSR_ASSERT_NEXT(a_ack_advances, in_fire && ack_nxt, phase_r != $past(phase_r),
    "answered byte did not advance the phase")

endmodule

[bench/tb.sv]
// Self-checking bench for the digital pad serial responder: polls, latches, noise.
`timescale 1ns / 1ps

module tb;
  import dpsr_pkg::*;

  // Action code with no meaning to the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One result beat: the bit sent back and the acknowledge flag
  typedef struct packed {
    logic tx_bit;
    logic ack_pulse;
  } reply_t;

  // Tracks the pad's protocol state and the replies still owed by the block
  class pad_scoreboard;
    reply_t      replies_due[$];
    logic        selected;
    logic [2:0]  bit_pos;
    phase_t      ph;
    logic [7:0]  rx_shift;
    logic [7:0]  tx_shift;
    logic [15:0] btn_word;
    int unsigned mismatches;
    int unsigned beats;
    int unsigned acks;
    int unsigned full_reads;

    function new();
      selected   = 1'b0;
      bit_pos    = '0;
      ph         = PH_WAIT_START;
      rx_shift   = '0;
      tx_shift   = TX_IDLE;
      btn_word   = ALL_RELEASED;
      mismatches = 0;
      beats      = 0;
      acks       = 0;
      full_reads = 0;
    endfunction

    // Reply to one accepted input beat; returns 0 when the beat is ignored
    function bit predict_reply(logic [1:0] act, logic [15:0] pressed, logic level, logic din);
      reply_t r;
      bit     live;
      r.tx_bit    = 1'b1;
      r.ack_pulse = 1'b0;
      live        = 1'b1;
      case (act)
        ACT_LATCH: btn_word = (pressed & BTN_MASK) ^ ALL_RELEASED;
        ACT_SELECT: begin
          // rising edge restarts the exchange
          if (!selected && level) begin
            ph       = PH_WAIT_START;
            bit_pos  = '0;
            rx_shift = '0;
            tx_shift = TX_IDLE;
          end
          selected = level;
        end
        ACT_EXCHANGE: begin
          if (!selected) begin
            live = 1'b0;
          end else begin
            r.tx_bit          = tx_shift[bit_pos];
            tx_shift[bit_pos] = 1'b1;
            rx_shift[bit_pos] = din;
            if (bit_pos == LAST_BIT) begin
              bit_pos = '0;
              case (ph)
                PH_WAIT_START: begin
                  if (rx_shift == CMD_START) begin
                    r.ack_pulse = 1'b1;
                    tx_shift    = ANS_ID;
                    ph          = PH_WAIT_READ;
                  end
                end
                PH_WAIT_READ: begin
                  if (rx_shift == CMD_READ) begin
                    r.ack_pulse = 1'b1;
                    tx_shift    = ANS_READY;
                    ph          = PH_BTN_LO;
                  end
                end
                PH_BTN_LO: begin
                  r.ack_pulse = 1'b1;
                  tx_shift    = btn_word[7:0];
                  ph          = PH_BTN_HI;
                end
                PH_BTN_HI: begin
                  r.ack_pulse = 1'b1;
                  tx_shift    = btn_word[15:8];
                  ph          = PH_DONE;
                  full_reads++;
                end
                default: ;
              endcase
            end else begin
              bit_pos = bit_pos + 3'd1;
            end
          end
        end
        default: live = 1'b0;
      endcase
      if (r.ack_pulse) acks++;
      beats++;
      replies_due.push_back(r);
      return live;
    endfunction

    // Compare a result beat with the oldest reply owed
    function void check_reply(logic tx, logic ack);
      reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with no reply owed (tx_bit %b ack_pulse %b)", $realtime,
                   tx, ack);
        return;
      end
      want = replies_due.pop_front();
      if (tx !== want.tx_bit || ack !== want.ack_pulse) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: tx_bit expected %b got %b, ack_pulse expected %b got %b", $realtime,
                   want.tx_bit, tx, want.ack_pulse, ack);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dpsr_in_if  in_if ();
  dpsr_out_if out_if ();

  digital_pad_serial_responder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  pad_scoreboard sb;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   hold_len = 0;
  int unsigned   counted = 0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one input beat, idling beforehand at the current rate
  task automatic send_beat(logic [1:0] act, logic [15:0] pressed, logic level, logic din);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.action          <= act;
    in_if.buttons_pressed <= pressed;
    in_if.select_level    <= level;
    in_if.data_in         <= din;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (sb.predict_reply(act, pressed, level, din)) counted++;
  endtask

  task automatic latch_buttons(logic [15:0] pressed);
    send_beat(ACT_LATCH, pressed, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic set_select(logic level);
    send_beat(ACT_SELECT, 16'($urandom), level, 1'($urandom_range(1)));
  endtask

  // Eight exchange beats, LSB first
  task automatic exchange_byte(logic [7:0] b);
    for (int i = 0; i < 8; i++)
      send_beat(ACT_EXCHANGE, 16'($urandom), 1'($urandom_range(1)), b[i]);
  endtask

  // A host poll with random content; now and then a command byte is corrupted
  task automatic host_poll();
    logic [7:0] cmd;
    int         extra;
    if ($urandom_range(9) != 0) set_select(1'b0);
    set_select(1'b1);
    if ($urandom_range(1) != 0) latch_buttons(16'($urandom));
    cmd = ($urandom_range(9) == 0) ? 8'($urandom) : CMD_START;
    exchange_byte(cmd);
    cmd = ($urandom_range(9) == 0) ? 8'($urandom) : CMD_READ;
    exchange_byte(cmd);
    if ($urandom_range(3) == 0) latch_buttons(16'($urandom));
    exchange_byte(8'($urandom));
    exchange_byte(8'($urandom));
    extra = $urandom_range(2);
    repeat (extra) exchange_byte(8'($urandom));
    // sometimes break off mid-byte
    if ($urandom_range(4) == 0)
      repeat ($urandom_range(1, 7))
        send_beat(ACT_EXCHANGE, 16'($urandom), 1'b0, 1'($urandom_range(1)));
    if ($urandom_range(3) != 0) set_select(1'b0);
  endtask

  // Stop offering and wait for every owed reply
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  // Result side: check accepted beats, stall at random or for a forced hold
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready)
        sb.check_reply(out_if.tx_bit, out_if.ack_pulse);
      if (hold_len != 0) begin
        out_if.ready <= 1'b0;
        hold_len--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned phase_end [4];
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    bit          held;
    sb = new();
    phase_end = '{320, 640, 960, 1250};
    send_pct  = '{0, 66, 0, 15};
    recv_pct  = '{0, 0, 66, 15};
    held      = 1'b0;
    in_if.valid           <= 1'b0;
    in_if.action          <= ACT_LATCH;
    in_if.buttons_pressed <= '0;
    in_if.select_level    <= 1'b0;
    in_if.data_in         <= 1'b0;
    rst_n                 <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme words, unused action code, deselected bit, select edges
    latch_buttons(16'hffff);
    latch_buttons(16'h0000);
    send_beat(ACT_UNUSED, 16'hffff, 1'b1, 1'b1);
    send_beat(ACT_EXCHANGE, 16'h0000, 1'b0, 1'b1);
    set_select(1'b0);
    set_select(1'b1);
    set_select(1'b1);
    exchange_byte(CMD_START);
    set_select(1'b0);
    set_select(1'b0);
    drain();

    // Random polls and noise across the idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_pct[p];
      stall_pct     = recv_pct[p];
      while (counted < phase_end[p]) begin
        // long receiver hold while beats keep coming
        if (p == 0 && !held && counted > 150) begin
          hold_len = 400;
          held     = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          host_poll();
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("Ran %0d input beats (%0d effective), %0d acknowledged bytes, %0d full reads.",
             sb.beats, counted, sb.acks, sb.full_reads);
    $display("Idling phases: none, sender, receiver, both; %0d mismatches.", sb.mismatches);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
